// File: rtl/ccfq_pkg.sv
// shared constants and item types for the frame command filter queue
package ccfq_pkg;

  localparam int unsigned QUEUE_DEPTH = 64;
  localparam int unsigned ADDR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned IDX_W       = ADDR_W + 1;
  localparam int unsigned MAX_BYTES   = 8;
  localparam int unsigned CNT_W       = $clog2(MAX_BYTES + 1);
  localparam int unsigned LIMIT_W     = 9;
  localparam int unsigned CFG_IDX_W   = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COMMAND_LIMIT = 1'b0,
    CFG_IDLE_CODE     = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_READ,
    ST_DATA
  } ccfq_state_e;

  typedef struct packed {
    logic       frame_valid;
    logic [3:0] frame_length;
    logic [7:0] data_byte0;
    logic [7:0] data_byte1;
    logic [7:0] data_byte2;
    logic [7:0] data_byte3;
    logic [7:0] data_byte4;
    logic [7:0] data_byte5;
    logic [7:0] data_byte6;
    logic [7:0] data_byte7;
  } in_item_t;

  typedef struct packed {
    logic       frame_received;
    logic [7:0] command_out;
    logic       command_present;
    logic       overflow;
  } out_item_t;

endpackage

// File: rtl/can_command_filter_queue.sv
// top level of the frame command filter queue
// Each item is one poll. The block accepts it, then scans one data byte per
// cycle (length saturated to eight, none when no frame is flagged), writing
// each byte below command_limit into a single-port 64-entry store, then reads
// the oldest entry in ST_READ and forms the result in ST_DATA. The result
// sits in an output register, so the next item is taken while it waits. Bytes
// that find the store full are dropped and flagged; the store empties only when
// a poll finds it fully drained, which clears both indices and returns idle_code.
module can_command_filter_queue (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ccfq_pkg::in_item_t              in_item_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  output ccfq_pkg::out_item_t             out_item_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [ccfq_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ccfq_pkg::LIMIT_W-1:0]    cfg_data_i
);
  import ccfq_pkg::*;

  ccfq_state_e         state_q, state_d;
  in_item_t            item_q, item_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [CNT_W-1:0]    len_q, len_d;
  logic [IDX_W-1:0]    wr_q, wr_d;
  logic [IDX_W-1:0]    rd_q, rd_d;
  logic                drop_q, drop_d;
  logic                pop_q, pop_d;
  out_item_t           out_q, out_d;
  logic                out_valid_q, out_valid_d;
  logic [LIMIT_W-1:0]  limit_q;
  logic [7:0]          idle_q;
  logic                mem_we, mem_re;
  logic [ADDR_W-1:0]   mem_addr;
  logic [7:0]          mem_rdata;
  logic [7:0]          cur_byte;
  logic [CNT_W-1:0]    in_len;

  ccfq_store u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (cur_byte),
    .rdata_o (mem_rdata)
  );

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_W'(256);
      idle_q  <= 8'd0;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_COMMAND_LIMIT: limit_q <= cfg_data_i;
        CFG_IDLE_CODE:     idle_q  <= cfg_data_i[7:0];
        default:           limit_q <= limit_q;
      endcase
    end
  end

  always_comb begin
    case (cnt_q[2:0])
      3'd0:    cur_byte = item_q.data_byte0;
      3'd1:    cur_byte = item_q.data_byte1;
      3'd2:    cur_byte = item_q.data_byte2;
      3'd3:    cur_byte = item_q.data_byte3;
      3'd4:    cur_byte = item_q.data_byte4;
      3'd5:    cur_byte = item_q.data_byte5;
      3'd6:    cur_byte = item_q.data_byte6;
      default: cur_byte = item_q.data_byte7;
    endcase
  end

  // saturated length, zero without a frame
  assign in_len = !in_item_i.frame_valid ? CNT_W'(0) :
                  (in_item_i.frame_length > CNT_W'(MAX_BYTES)) ? CNT_W'(MAX_BYTES) :
                  in_item_i.frame_length;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      len_q       <= '0;
      wr_q        <= '0;
      rd_q        <= '0;
      drop_q      <= 1'b0;
      pop_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      len_q       <= len_d;
      wr_q        <= wr_d;
      rd_q        <= rd_d;
      drop_q      <= drop_d;
      pop_q       <= pop_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    out_q  <= out_d;
  end

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    cnt_d       = cnt_q;
    len_d       = len_q;
    wr_d        = wr_q;
    rd_d        = rd_q;
    drop_d      = drop_q;
    pop_d       = pop_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_addr    = wr_q[ADDR_W-1:0];

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          item_d  = in_item_i;
          len_d   = in_len;
          cnt_d   = '0;
          drop_d  = 1'b0;
          state_d = (in_len == '0) ? ST_READ : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if ({1'b0, cur_byte} < limit_q) begin
          if (wr_q < IDX_W'(QUEUE_DEPTH)) begin
            mem_we = 1'b1;
            wr_d   = wr_q + 1'b1;
          end else begin
            drop_d = 1'b1;
          end
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_d == len_q) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        mem_addr = rd_q[ADDR_W-1:0];
        if (rd_q < wr_q) begin
          mem_re = 1'b1;
          rd_d   = rd_q + 1'b1;
          pop_d  = 1'b1;
        end else begin
          rd_d  = '0;
          wr_d  = '0;
          pop_d = 1'b0;
        end
        state_d = ST_DATA;
      end
      ST_DATA: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.frame_received  = item_q.frame_valid;
          out_d.command_out     = pop_q ? mem_rdata : idle_q;
          out_d.command_present = pop_q;
          out_d.overflow        = drop_q;
          out_valid_d           = 1'b1;
          state_d               = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_item_o  = out_q;
  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/ccfq_store.sv
// single-port command store with registered read data
module ccfq_store (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic                       re_i,
  input  logic [ccfq_pkg::ADDR_W-1:0] addr_i,
  input  logic [7:0]                 wdata_i,
  output logic [7:0]                 rdata_o
);
  import ccfq_pkg::*;

  logic [7:0] mem_q [QUEUE_DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/ccfq_checker.sv
// port-level checks for the frame command filter queue
module ccfq_port_checks (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input ccfq_pkg::out_item_t out_item_o,
  input logic                out_valid_o,
  input logic                out_stall_i
);
  import ccfq_pkg::*;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("block not busy after taking an item");

  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without an item in progress");

  a_no_overflow_without_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.frame_received |-> !out_item_o.overflow)
    else $error("overflow flagged on a poll without a frame");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

endmodule

bind can_command_filter_queue ccfq_port_checks u_ccfq_port_checks (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_item_o  (out_item_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i)
);

// File: verif/ccfq_checker.sv
// scoreboard for the frame command filter queue: tracks the store and compares every result item
module ccfq_checker
  import ccfq_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  in_item_t              in_item_i,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  out_item_t             out_item_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [LIMIT_W-1:0]    cfg_data_i,
  output int                    err_count_o,
  output int                    pending_o
);

  logic [7:0]         cmd_store [QUEUE_DEPTH];
  logic [IDX_W-1:0]   wr_idx;
  logic [IDX_W-1:0]   rd_idx;
  logic [LIMIT_W-1:0] cmd_limit;
  logic [7:0]         idle_cmd;
  out_item_t          expected_cmds [$];
  int                 mismatches;
  int                 waiting;

  assign err_count_o = mismatches;
  assign pending_o   = waiting;

  function automatic out_item_t filter_and_pop(input in_item_t poll);
    logic [63:0] payload;
    logic [7:0]  data;
    int          count;
    int          b;
    out_item_t   res;
    payload = {poll.data_byte0, poll.data_byte1, poll.data_byte2, poll.data_byte3,
               poll.data_byte4, poll.data_byte5, poll.data_byte6, poll.data_byte7};
    count = (poll.frame_length > 4'd8) ? 8 : int'(poll.frame_length);
    res = '0;
    res.frame_received = poll.frame_valid;
    if (poll.frame_valid) begin
      for (b = 0; b < count; b++) begin
        data = payload[63 - 8*b -: 8];
        if ({1'b0, data} < cmd_limit) begin
          if (wr_idx < QUEUE_DEPTH) begin
            cmd_store[wr_idx[ADDR_W-1:0]] = data;
            wr_idx = wr_idx + 1'b1;
          end else begin
            res.overflow = 1'b1;
          end
        end
      end
    end
    if (rd_idx < wr_idx) begin
      res.command_out     = cmd_store[rd_idx[ADDR_W-1:0]];
      res.command_present = 1'b1;
      rd_idx = rd_idx + 1'b1;
    end else begin
      // drained: both indices start over
      rd_idx = '0;
      wr_idx = '0;
      res.command_out = idle_cmd;
    end
    return res;
  endfunction

  task automatic check_field(input string field, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      wr_idx     = '0;
      rd_idx     = '0;
      cmd_limit  = 9'd256;
      idle_cmd   = 8'h00;
      mismatches = 0;
      waiting    = 0;
      expected_cmds.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_cmds.size() == 0) begin
          $display("%0t: unexpected item, expected none actual %0h", $time, out_item_i);
          mismatches++;
        end else begin
          want = expected_cmds.pop_front();
          check_field("frame_received", want.frame_received, out_item_i.frame_received);
          check_field("command_out", want.command_out, out_item_i.command_out);
          check_field("command_present", want.command_present, out_item_i.command_present);
          check_field("overflow", want.overflow, out_item_i.overflow);
        end
      end
      if (in_valid_i && !in_stall_i)
        expected_cmds.push_back(filter_and_pop(in_item_i));
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_COMMAND_LIMIT)
          cmd_limit = cfg_data_i;
        else
          idle_cmd = cfg_data_i[7:0];
      end
      waiting = expected_cmds.size();
    end
  end

endmodule

// File: verif/tb_top.sv
// testbench top for the frame command filter queue: stimulus, idling and verdict
module tb_top;
  import ccfq_pkg::*;

  localparam int CYCLE_LIMIT   = 300000;
  localparam int SETTLE_CYCLES = 20;
  localparam int HOLD_CYCLES   = 200;
  localparam int PHASE_ITEMS   = 260;

  logic                 clk;
  logic                 rst_n        = 1'b0;
  in_item_t             poll_item    = '0;
  logic                 poll_valid   = 1'b0;
  logic                 in_stall;
  out_item_t            result_item;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  logic                 cfg_valid    = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index    = CFG_COMMAND_LIMIT;
  logic [LIMIT_W-1:0]   cfg_data     = '0;

  int                   err_count;
  int                   pending_cmds;
  int                   cycle_count   = 0;
  int                   send_idle_pct = 0;
  int                   recv_idle_pct = 0;
  int                   hold_ask      = 0;
  logic [LIMIT_W-1:0]   cur_limit     = 9'd256;

  can_command_filter_queue i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_item_i   (poll_item),
    .in_valid_i  (poll_valid),
    .in_stall_o  (in_stall),
    .out_item_o  (result_item),
    .out_valid_o (result_valid),
    .out_stall_i (result_stall),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  ccfq_checker i_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_item_i   (poll_item),
    .in_valid_i  (poll_valid),
    .in_stall_i  (in_stall),
    .out_item_i  (result_item),
    .out_valid_i (result_valid),
    .out_stall_i (result_stall),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .err_count_o (err_count),
    .pending_o   (pending_cmds)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // result side: random stalls, plus a long hold-off on request
  initial begin
    int seen;
    seen = 0;
    forever begin
      @(negedge clk);
      if (hold_ask != seen) begin
        seen = hold_ask;
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        result_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  task automatic send_poll(input in_item_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      poll_valid <= 1'b0;
      @(negedge clk);
    end
    poll_item  <= item;
    poll_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic settle();
    poll_valid <= 1'b0;
    while (pending_cmds != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic load_config(input logic [LIMIT_W-1:0] limit, input logic [7:0] idle);
    cur_limit = limit;
    cfg_valid <= 1'b1;
    cfg_index <= CFG_COMMAND_LIMIT;
    cfg_data  <= limit;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_index <= CFG_IDLE_CODE;
    cfg_data  <= {1'b0, idle};
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic in_item_t random_poll(input bit filling);
    logic [63:0] payload;
    logic        valid;
    logic [3:0]  len;
    int          k;
    int          hi;
    hi = (cur_limit >= 9'd256) ? 255 : int'(cur_limit) - 1;
    payload = '0;
    for (k = 0; k < 8; k++) begin
      if (filling && cur_limit != 0 && $urandom_range(3) != 0)
        payload = {payload[55:0], 8'($urandom_range(hi))};
      else
        payload = {payload[55:0], 8'($urandom)};
    end
    if (filling) begin
      valid = ($urandom_range(9) != 0);
      len = ($urandom_range(7) == 0) ? 4'($urandom_range(15, 9)) : 4'($urandom_range(8));
    end else begin
      // draining polls: no frame, or an empty one
      valid = ($urandom_range(3) == 0);
      len = valid ? 4'd0 : 4'($urandom_range(15));
    end
    return {valid, len, payload};
  endfunction

  task automatic random_phase(input int send_pct, input int recv_pct, input bit with_hold);
    int n;
    int run;
    bit filling;
    settle();
    load_config((send_pct == 0) ? 9'($urandom_range(256)) :
                (recv_pct > send_pct) ? 9'($urandom_range(255, 1)) : 9'd256,
                8'($urandom));
    send_idle_pct = send_pct;
    recv_idle_pct <= recv_pct;
    n = 0;
    while (n < PHASE_ITEMS) begin
      filling = $urandom_range(1);
      run = filling ? $urandom_range(12, 1) : $urandom_range(80, 5);
      while (run > 0 && n < PHASE_ITEMS) begin
        send_poll(random_poll(filling));
        n++;
        run--;
        if (with_hold && n == PHASE_ITEMS / 2)
          hold_ask <= hold_ask + 1;
      end
    end
  endtask

  initial begin
    int k;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    load_config(9'd256, 8'h00);

    send_poll('0);
    send_poll({1'b0, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF});
    send_poll({1'b1, 4'd0, 64'h1234_5678_9ABC_DEF0});
    send_poll({1'b1, 4'd8, 64'h00FF_01FE_807F_55AA});
    send_poll({1'b1, 4'd15, 64'h0102_0408_1020_4080});
    for (k = 1; k <= 7; k++)
      send_poll({1'b1, 4'd8, {8{8'(k)}}});
    // store full although entries were already popped
    send_poll({1'b1, 4'd1, 64'h3C00_0000_0000_0000});
    send_poll({1'b0, 4'd3, 64'h0101_0101_0101_0101});

    settle();
    load_config(9'd0, 8'hFF);
    send_poll({1'b1, 4'd8, 64'h0000_0000_0000_0000});

    settle();
    load_config(9'd128, 8'hA5);
    send_poll({1'b1, 4'd2, 64'h7F80_0000_0000_0000});
    send_poll({1'b1, 4'd8, 64'h8080_FFFF_C0C0_9090});

    random_phase(33, 79, 1'b0);
    random_phase(79, 33, 1'b0);
    random_phase(0, 0, 1'b1);

    settle();
    if (err_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

// File: files.f
rtl/ccfq_pkg.sv
rtl/ccfq_store.sv
rtl/can_command_filter_queue.sv
rtl/ccfq_checker.sv
verif/ccfq_checker.sv
verif/tb_top.sv
